// ===== rtl/atd_pkg.sv =====
`timescale 1ns / 1ps
// atd_pkg: shared constants, codes and controller/datapath types for the
// adaptive transient detector. No dependencies.

package atd_pkg;

  // Defaults handed to the top-level parameters
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int RUN_BITS_DEF    = 8;

  // Variance estimate, unsigned Q18.16
  localparam int                VAR_W     = 34;
  localparam logic [VAR_W-1:0]  VAR_FLOOR = 34'd7;
  localparam logic [VAR_W-1:0]  VAR_MAX   = {VAR_W{1'b1}};
  localparam int                FRAC_W    = 16;

  // Shared multiplier and accumulator. Sample widths top out at 24 bits,
  // so the largest sum (1311 * dev^2 with 48-bit dev^2) stays below 2^60.
  localparam int MUL_W      = 24;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 60;
  localparam int VAR_SPLIT  = 17;
  localparam int DEV2_SPLIT = MUL_W;

  // Exponential average weights (old, new) over 2^16
  localparam logic [15:0] W_OLD = 16'd64225;
  localparam logic [15:0] W_NEW = 16'd1311;

  // Configuration registers
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int THR_W     = 16;
  localparam int KS_W      = 12;
  localparam int REQ_W     = 8;

  localparam logic [THR_W-1:0] THR_RST = 16'd256;
  localparam logic [KS_W-1:0]  KS_RST  = 12'd768;
  localparam logic [REQ_W-1:0] REQ_RST = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THR_FLOOR     = 2'd0,
    CFG_K_SIGMA       = 2'd1,
    CFG_REQUIRED_RUN  = 2'd2
  } cfg_idx_t;

  // Product issued to the shared multiplier; it also tags what the
  // datapath does with that product in the cycle after.
  typedef enum logic [3:0] {
    MUL_NONE    = 4'd0,
    MUL_SQR     = 4'd1,
    MUL_KSQ     = 4'd2,
    MUL_BND_LO  = 4'd3,
    MUL_BND_HI  = 4'd4,
    MUL_UPD_VLO = 4'd5,
    MUL_UPD_VHI = 4'd6,
    MUL_UPD_DLO = 4'd7,
    MUL_UPD_DHI = 4'd8
  } mul_op_t;

  typedef struct packed {
    logic    accept;
    mul_op_t mul_op;
    logic    seed;
    logic    judge;
    logic    var_update;
    logic    clear_run;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic exceed;
  } dp_status_t;

endpackage

// ===== rtl/atd_sample_if.sv =====
`timescale 1ns / 1ps
// atd_sample_if: input channel of the transient detector (valid/ready plus
// one sample or clear word). Depends on atd_pkg.

interface atd_sample_if #(
  parameter int SAMPLE_BITS = atd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [SAMPLE_BITS-1:0] instant_value;
  logic signed [SAMPLE_BITS-1:0] average_value;

  modport source (output valid, kind, instant_value, average_value, input ready);
  modport sink   (input valid, kind, instant_value, average_value, output ready);
endinterface

// ===== rtl/atd_result_if.sv =====
`timescale 1ns / 1ps
// atd_result_if: result channel of the transient detector (valid/ready,
// detection flag and variance). Depends on atd_pkg.

interface atd_result_if;
  logic                        valid;
  logic                        ready;
  logic                        detected;
  logic [atd_pkg::VAR_W-1:0]   variance_now;

  modport source (output valid, detected, variance_now, input ready);
  modport sink   (input valid, detected, variance_now, output ready);
endinterface

// ===== rtl/atd_ctrl.sv =====
`timescale 1ns / 1ps
// atd_ctrl: sequencer for the detector. Steps the shared multiplier through
// one word and owns the handshakes. Depends on atd_pkg.

module atd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  atd_pkg::dp_status_t status,
  output atd_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [14:0] {
    S_IDLE      = 15'h0001,
    S_SQR       = 15'h0002,
    S_KSQ       = 15'h0004,
    S_SEED      = 15'h0008,
    S_BND_LO    = 15'h0010,
    S_BND_HI    = 15'h0020,
    S_BND_WAIT  = 15'h0040,
    S_JUDGE     = 15'h0080,
    S_UPD_VLO   = 15'h0100,
    S_UPD_VHI   = 15'h0200,
    S_UPD_DLO   = 15'h0400,
    S_UPD_DHI   = 15'h0800,
    S_UPD_WAIT  = 15'h1000,
    S_UPD_END   = 15'h2000,
    S_DONE      = 15'h4000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_op = atd_pkg::MUL_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_SQR;
        end
      end
      S_SQR: begin
        if (status.is_clear) begin
          cmd.clear_run = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.mul_op = atd_pkg::MUL_SQR;
          state_next = S_KSQ;
        end
      end
      S_KSQ: begin
        cmd.mul_op = atd_pkg::MUL_KSQ;
        state_next = S_SEED;
      end
      S_SEED: begin
        cmd.seed   = 1'b1;
        state_next = S_BND_LO;
      end
      S_BND_LO: begin
        cmd.mul_op = atd_pkg::MUL_BND_LO;
        state_next = S_BND_HI;
      end
      S_BND_HI: begin
        cmd.mul_op = atd_pkg::MUL_BND_HI;
        state_next = S_BND_WAIT;
      end
      S_BND_WAIT: begin
        state_next = S_JUDGE;
      end
      S_JUDGE: begin
        cmd.judge  = 1'b1;
        state_next = status.exceed ? S_DONE : S_UPD_VLO;
      end
      S_UPD_VLO: begin
        cmd.mul_op = atd_pkg::MUL_UPD_VLO;
        state_next = S_UPD_VHI;
      end
      S_UPD_VHI: begin
        cmd.mul_op = atd_pkg::MUL_UPD_VHI;
        state_next = S_UPD_DLO;
      end
      S_UPD_DLO: begin
        cmd.mul_op = atd_pkg::MUL_UPD_DLO;
        state_next = S_UPD_DHI;
      end
      S_UPD_DHI: begin
        cmd.mul_op = atd_pkg::MUL_UPD_DHI;
        state_next = S_UPD_WAIT;
      end
      S_UPD_WAIT: begin
        state_next = S_UPD_END;
      end
      S_UPD_END: begin
        cmd.var_update = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/atd_datapath.sv =====
`timescale 1ns / 1ps
// atd_datapath: config registers, deviation, shared 24x24 multiplier with
// accumulator, variance and run state, result register. Depends on atd_pkg.

module atd_datapath #(
  parameter int SAMPLE_BITS = atd_pkg::SAMPLE_BITS_DEF,
  parameter int RUN_BITS    = atd_pkg::RUN_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  atd_pkg::ctrl_cmd_t                   cmd,
  output atd_pkg::dp_status_t                  status,
  input  logic                                 cfg_write,
  input  logic [atd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [atd_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_kind,
  input  logic signed [SAMPLE_BITS-1:0]        in_instant,
  input  logic signed [SAMPLE_BITS-1:0]        in_average,
  output logic                                 res_detected,
  output logic [atd_pkg::VAR_W-1:0]            res_variance
);

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int DEV2_W = 2 * SAMPLE_BITS;
  localparam int K2_W   = 2 * atd_pkg::KS_W;
  localparam int CMP_W  = (RUN_BITS > atd_pkg::REQ_W) ? RUN_BITS : atd_pkg::REQ_W;
  localparam int MAGC_W = (SAMPLE_BITS > atd_pkg::THR_W) ? SAMPLE_BITS : atd_pkg::THR_W;

  // config
  logic [atd_pkg::THR_W-1:0] thr_floor;
  logic [atd_pkg::KS_W-1:0]  k_sigma;
  logic [atd_pkg::REQ_W-1:0] required_run;

  // word state
  logic                      kind;
  logic [SAMPLE_BITS-1:0]    mag;
  logic [DEV2_W-1:0]         dev2;
  logic [K2_W-1:0]           k2;
  logic                      detected;

  // persistent state
  logic [atd_pkg::VAR_W-1:0] variance;
  logic                      primed;
  logic [RUN_BITS-1:0]       run_count;

  // multiplier and accumulator
  logic [atd_pkg::MUL_W-1:0]  op_a;
  logic [atd_pkg::MUL_W-1:0]  op_b;
  logic [atd_pkg::PROD_W-1:0] prod;
  atd_pkg::mul_op_t           pend_op;
  logic [atd_pkg::ACC_W-1:0]  acc;
  logic [atd_pkg::ACC_W-1:0]  prod_ext;
  logic [atd_pkg::ACC_W-1:0]  prod_sh;
  logic [atd_pkg::ACC_W-1:0]  bound;
  logic [atd_pkg::ACC_W-1:0]  seed_sum;
  logic [atd_pkg::PROD_W-1:0] dev2_ext;

  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          diff_abs;
  logic [RUN_BITS-1:0]        run_inc;
  logic                       exceed;

  function automatic logic [atd_pkg::VAR_W-1:0] var_sat(input logic [atd_pkg::ACC_W-1:0] v);
    if (v > atd_pkg::ACC_W'(atd_pkg::VAR_MAX)) begin
      return atd_pkg::VAR_MAX;
    end
    return v[atd_pkg::VAR_W-1:0];
  endfunction

  // |instant - average| fits SAMPLE_BITS unsigned
  assign diff     = DIFF_W'(in_instant) - DIFF_W'(in_average);
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  assign dev2_ext = atd_pkg::PROD_W'(dev2);
  assign prod_ext = atd_pkg::ACC_W'(prod);
  assign bound    = acc >> atd_pkg::FRAC_W;
  assign seed_sum = atd_pkg::ACC_W'(dev2) + atd_pkg::ACC_W'(atd_pkg::VAR_FLOOR);

  // mag over thr_floor, and dev^2 against floor(k^2 * var / 2^16): exact, as dev^2 is whole
  assign exceed = (MAGC_W'(mag) > MAGC_W'(thr_floor)) &&
                  (atd_pkg::ACC_W'(dev2) > bound);

  assign run_inc = (run_count == {RUN_BITS{1'b1}}) ? run_count
                                                   : RUN_BITS'(run_count + 1'b1);

  assign status.is_clear = kind;
  assign status.exceed   = exceed;

  // operand select
  always_comb begin
    unique case (cmd.mul_op)
      atd_pkg::MUL_SQR: begin
        op_a = atd_pkg::MUL_W'(mag);
        op_b = atd_pkg::MUL_W'(mag);
      end
      atd_pkg::MUL_KSQ: begin
        op_a = atd_pkg::MUL_W'(k_sigma);
        op_b = atd_pkg::MUL_W'(k_sigma);
      end
      atd_pkg::MUL_BND_LO: begin
        op_a = atd_pkg::MUL_W'(k2);
        op_b = atd_pkg::MUL_W'(variance[atd_pkg::VAR_SPLIT-1:0]);
      end
      atd_pkg::MUL_BND_HI: begin
        op_a = atd_pkg::MUL_W'(k2);
        op_b = atd_pkg::MUL_W'(variance[atd_pkg::VAR_W-1:atd_pkg::VAR_SPLIT]);
      end
      atd_pkg::MUL_UPD_VLO: begin
        op_a = atd_pkg::MUL_W'(atd_pkg::W_OLD);
        op_b = atd_pkg::MUL_W'(variance[atd_pkg::VAR_SPLIT-1:0]);
      end
      atd_pkg::MUL_UPD_VHI: begin
        op_a = atd_pkg::MUL_W'(atd_pkg::W_OLD);
        op_b = atd_pkg::MUL_W'(variance[atd_pkg::VAR_W-1:atd_pkg::VAR_SPLIT]);
      end
      atd_pkg::MUL_UPD_DLO: begin
        op_a = atd_pkg::MUL_W'(atd_pkg::W_NEW);
        op_b = dev2_ext[atd_pkg::DEV2_SPLIT-1:0];
      end
      atd_pkg::MUL_UPD_DHI: begin
        op_a = atd_pkg::MUL_W'(atd_pkg::W_NEW);
        op_b = dev2_ext[atd_pkg::PROD_W-1:atd_pkg::DEV2_SPLIT];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // align the registered product for the accumulator
  always_comb begin
    unique case (pend_op)
      atd_pkg::MUL_BND_HI,
      atd_pkg::MUL_UPD_VHI: prod_sh = prod_ext << atd_pkg::VAR_SPLIT;
      atd_pkg::MUL_UPD_DHI: prod_sh = prod_ext << atd_pkg::DEV2_SPLIT;
      default:              prod_sh = prod_ext;
    endcase
  end

  // multiplier, product register and its follow-up
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    unique case (pend_op)
      atd_pkg::MUL_SQR:     dev2 <= DEV2_W'(prod);
      atd_pkg::MUL_KSQ:     k2   <= K2_W'(prod);
      atd_pkg::MUL_BND_LO,
      atd_pkg::MUL_UPD_VLO: acc  <= prod_sh;
      atd_pkg::MUL_BND_HI,
      atd_pkg::MUL_UPD_VHI,
      atd_pkg::MUL_UPD_DLO,
      atd_pkg::MUL_UPD_DHI: acc  <= acc + prod_sh;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_op <= atd_pkg::MUL_NONE;
    end else begin
      pend_op <= cmd.mul_op;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_floor     <= atd_pkg::THR_RST;
      k_sigma       <= atd_pkg::KS_RST;
      required_run  <= atd_pkg::REQ_RST;
    end else if (cfg_write) begin
      unique case (atd_pkg::cfg_idx_t'(cfg_index))
        atd_pkg::CFG_THR_FLOOR:     thr_floor     <= cfg_data[atd_pkg::THR_W-1:0];
        atd_pkg::CFG_K_SIGMA:       k_sigma       <= cfg_data[atd_pkg::KS_W-1:0];
        atd_pkg::CFG_REQUIRED_RUN: begin
          // zero means one
          if (cfg_data[atd_pkg::REQ_W-1:0] == '0) begin
            required_run <= atd_pkg::REQ_RST;
          end else begin
            required_run <= cfg_data[atd_pkg::REQ_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // word capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind     <= in_kind;
      mag      <= diff_abs[SAMPLE_BITS-1:0];
      detected <= 1'b0;
    end else if (cmd.judge && exceed &&
                 (CMP_W'(run_inc) >= CMP_W'(required_run))) begin
      detected <= 1'b1;
    end
  end

  // variance, priming and run
  always_ff @(posedge clk) begin
    if (rst) begin
      variance  <= atd_pkg::VAR_FLOOR;
      primed    <= 1'b0;
      run_count <= '0;
    end else begin
      if (cmd.seed && !primed) begin
        variance <= var_sat(seed_sum);
        primed   <= 1'b1;
      end else if (cmd.var_update) begin
        variance <= var_sat(bound);
      end
      if (cmd.clear_run) begin
        run_count <= '0;
      end else if (cmd.judge) begin
        if (exceed && (CMP_W'(run_inc) < CMP_W'(required_run))) begin
          run_count <= run_inc;
        end else begin
          run_count <= '0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_detected <= detected;
      res_variance <= variance;
    end
  end

endmodule

// ===== rtl/adaptive_transient_detector_core.sv =====
`timescale 1ns / 1ps
// adaptive_transient_detector_core: top level of the k-sigma transient
// detector. Depends on atd_pkg, atd_sample_if, atd_result_if, atd_ctrl and atd_datapath.
//
//   channel   dir   handshake      word
//   -------   ---   ------------   --------------------------------------------
//   sample    in    valid/ready    kind, instant_value, average_value (Q8.8)
//   result    out   valid/ready    detected, variance_now (Q18.16)
//   cfg       in    cfg_write      cfg_index, cfg_data (no read-back)
//
// One word in flight: the next word is accepted only after the last result
// is loaded into the output register. The single 24x24 multiplier works
// through up to eight products in turn (dev^2, k^2, two for the bound, four
// for the variance update); a clear word needs none of them.
// Synchronous reset restores the config defaults, zeroes the run, sets the
// variance to its floor and marks it unseeded. A result waiting in the output
// register does not block acceptance; only the next finished word waits for
// it to be taken.

module adaptive_transient_detector_core #(
  parameter int SAMPLE_BITS = atd_pkg::SAMPLE_BITS_DEF,
  parameter int RUN_BITS    = atd_pkg::RUN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  atd_sample_if.sink                    sample,
  atd_result_if.source                  result,
  input  logic                          cfg_write,
  input  logic [atd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [atd_pkg::CFG_W-1:0]     cfg_data
);

  // controller <-> datapath
  atd_pkg::ctrl_cmd_t  cmd;
  atd_pkg::dp_status_t status;

  // Sequencer: owns both handshakes and steps the multiplier.
  atd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic, state and the result register.
  atd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .RUN_BITS    (RUN_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_kind      (sample.kind),
    .in_instant   (sample.instant_value),
    .in_average   (sample.average_value),
    .res_detected (result.detected),
    .res_variance (result.variance_now)
  );

endmodule
